[design/conv3_pkg.sv]
// Shared types and constants for the 3x3 RGB convolution filter.
// Used by conv3x3_rgb_const_border. No dependencies.
`default_nettype none

package conv3_pkg;

	// Default sizes
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int COEF_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_TOP = 3'd0,
		CFG_COEF_MID = 3'd1,
		CFG_COEF_BOT = 3'd2,
		CFG_WIDTH    = 3'd3,
		CFG_HEIGHT   = 3'd4,
		CFG_BORDER   = 3'd5
	} cfg_idx_t;

	// Register reset values
	localparam logic [47:0] COEF_RESET   = 48'h01C7_01C7_01C7;
	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [7:0]  BORDER_RESET = 8'd128;

	// Input opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] pixel_ch0;
		logic [7:0] pixel_ch1;
		logic [7:0] pixel_ch2;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_ch0;
		logic [7:0] out_ch1;
		logic [7:0] out_ch2;
		logic       end_of_frame;
	} res_t;

	// Per-item control carried down the pipeline
	typedef struct packed {
		logic emit;
		logic top_out;
		logic bot_out;
		logic left_out;
		logic right_out;
		logic eof;
	} ctl_t;

endpackage

`default_nettype wire

[design/conv3x3_rgb_const_border.sv]
// Streaming 3x3 convolution over three-channel 8-bit pixels, constant border.
// Items pass line memory, window and product stages into the output register.
// Throughput: one item per clock while unstalled; output trails by one row plus one pixel.
// The two previous rows sit in one MAX_WIDTH x 48-bit line memory (read/modify/write).
// Reset clears config to defaults, position counters, window and pipeline valids;
// the line memory is not cleared (its stale entries only feed border-masked taps).
`default_nettype none

module conv3x3_rgb_const_border
	import conv3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int COEF_BITS = COEF_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire pix_t                  pix,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_t                       res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int FR = COEF_BITS - 4;
	localparam int PW = COEF_BITS + 9;
	localparam int SW = PW + 4;
	localparam int LW = CW + 13;

	// Configuration registers
	logic [47:0] coef_q [3];
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [7:0]  border_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= COEF_RESET;
			coef_q[1] <= COEF_RESET;
			coef_q[2] <= COEF_RESET;
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			border_q  <= BORDER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COEF_TOP: coef_q[0] <= cfg_wdata[47:0];
				CFG_COEF_MID: coef_q[1] <= cfg_wdata[47:0];
				CFG_COEF_BOT: coef_q[2] <= cfg_wdata[47:0];
				CFG_WIDTH:    width_q   <= cfg_wdata[10:0];
				CFG_HEIGHT:   height_q  <= cfg_wdata[12:0];
				CFG_BORDER:   border_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Effective frame size
	logic [CW-1:0] eff_w;
	logic [12:0]   eff_h;
	logic [LW-1:0] last_pos;

	always_comb begin
		if (width_q == 11'd0)
			eff_w = CW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			eff_w = CW'(MAX_WIDTH);
		else
			eff_w = CW'(width_q);
		eff_h    = (height_q == 13'd0) ? 13'd1 : height_q;
		last_pos = LW'(eff_w) * LW'(eff_h) - LW'(1);
	end

	// Coefficient unpack, bits past the register read as zero
	logic signed [COEF_BITS-1:0] coef [3][3];

	always_comb begin
		for (int n = 0; n < 3; n++)
			for (int m = 0; m < 3; m++)
				coef[n][m] = COEF_BITS'(64'(coef_q[n]) >> (m * COEF_BITS));
	end

	// Global pipeline advance
	logic  adv;
	res_t  res_q;
	logic  res_valid_q;

	assign adv       = !res_valid_q || res_ready;
	assign pix_ready = adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Stage 0: position counters and item decode
	logic [XW-1:0] col_q;
	logic [12:0]   row_q;
	logic [XW-1:0] ocol_q;
	logic [21:0]   orow_q;
	logic [21:0]   opos_q;

	logic          past_end, take;
	logic [23:0]   bot_pix;
	ctl_t          ctl_in;
	logic          col_wrap;

	always_comb begin
		past_end = row_q >= eff_h;
		take     = pix_valid && pix_ready && !(!past_end && pix.opcode == OP_DRAIN);
		bot_pix  = past_end ? {border_q, border_q, border_q}
		                    : {pix.pixel_ch2, pix.pixel_ch1, pix.pixel_ch0};
		col_wrap = (CW'(col_q) + CW'(1)) >= eff_w;

		ctl_in.emit      = (row_q >= 13'd2) || (row_q == 13'd1 && col_q != '0);
		ctl_in.top_out   = orow_q == 22'd0;
		ctl_in.bot_out   = (23'(orow_q) + 23'd1) >= 23'(eff_h);
		ctl_in.left_out  = ocol_q == '0;
		ctl_in.right_out = (CW'(ocol_q) + CW'(1)) >= eff_w;
		ctl_in.eof       = 32'(opos_q) >= 32'(last_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			opos_q <= '0;
		end else if (take) begin
			if (ctl_in.emit && ctl_in.eof) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
				opos_q <= '0;
			end else begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + 13'd1;
				end else begin
					col_q <= col_q + XW'(1);
				end
				if (ctl_in.emit) begin
					opos_q <= opos_q + 22'd1;
					if (opos_q == '1) begin
						ocol_q <= '0;
						orow_q <= '0;
					end else if (ctl_in.right_out) begin
						ocol_q <= '0;
						orow_q <= orow_q + 22'd1;
					end else begin
						ocol_q <= ocol_q + XW'(1);
					end
				end
			end
		end
	end

	// Stage 1: line memory read/modify/write, {older row, newer row}
	logic [47:0]   line_mem [MAX_WIDTH];
	logic [47:0]   rd_s1;
	logic [47:0]   fwd_d_s1;
	logic          fwd_s1;
	logic          s1_v;
	logic [XW-1:0] addr_s1;
	logic [23:0]   bot_s1;
	ctl_t          ctl_s1;
	logic [23:0]   top_s1, mid_s1;

	assign top_s1 = fwd_s1 ? fwd_d_s1[47:24] : rd_s1[47:24];
	assign mid_s1 = fwd_s1 ? fwd_d_s1[23:0]  : rd_s1[23:0];

	always_ff @(posedge clk) begin
		if (take)
			rd_s1 <= line_mem[col_q];
		if (s1_v && adv)
			line_mem[addr_s1] <= {mid_s1, bot_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			s1_v   <= take;
			// same-entry write in the cycle of the read: bypass
			fwd_s1 <= take && s1_v && (addr_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_d_s1 <= {mid_s1, bot_s1};
			if (take) begin
				addr_s1 <= col_q;
				bot_s1  <= bot_pix;
				ctl_s1  <= ctl_in;
			end
		end
	end

	// Stage 2: column window, [col*3 + row]
	logic [23:0] win_q [9];
	logic        s2_v;
	ctl_t        ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
			for (int k = 0; k < 9; k++)
				win_q[k] <= '0;
		end else if (adv) begin
			s2_v <= s1_v && ctl_s1.emit;
			if (s1_v) begin
				for (int k = 0; k < 6; k++)
					win_q[k] <= win_q[k + 3];
				win_q[6] <= top_s1;
				win_q[7] <= mid_s1;
				win_q[8] <= bot_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_v)
			ctl_s2 <= ctl_s1;
	end

	// Border masking and products
	logic signed [PW-1:0] prod_c [3][9];

	always_comb begin
		logic [23:0] px;
		logic        outside;
		for (int n = 0; n < 3; n++) begin
			for (int m = 0; m < 3; m++) begin
				outside = (n == 0 && ctl_s2.top_out) || (n == 2 && ctl_s2.bot_out) ||
				          (m == 0 && ctl_s2.left_out) || (m == 2 && ctl_s2.right_out);
				px = outside ? {border_q, border_q, border_q} : win_q[m * 3 + n];
				for (int ch = 0; ch < 3; ch++)
					prod_c[ch][n * 3 + m] = PW'(coef[n][m]) *
						PW'($signed({1'b0, px[8 * ch +: 8]}));
			end
		end
	end

	// Stage 3: product registers
	logic signed [PW-1:0] prod_s3 [3][9];
	logic                 s3_v;
	logic                 eof_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s3_v <= 1'b0;
		else if (adv)
			s3_v <= s2_v;
	end

	always_ff @(posedge clk) begin
		if (adv && s2_v) begin
			prod_s3 <= prod_c;
			eof_s3  <= ctl_s2.eof;
		end
	end

	// Sum, round half up, saturate to 0..255
	logic [7:0] chan_out [3];

	always_comb begin
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] rnd;
		for (int ch = 0; ch < 3; ch++) begin
			sum = '0;
			for (int k = 0; k < 9; k++)
				sum = sum + SW'(prod_s3[ch][k]);
			rnd = (sum + (SW'(1) <<< (FR - 1))) >>> FR;
			if (sum <= 0)
				chan_out[ch] = 8'd0;
			else if (rnd > SW'(255))
				chan_out[ch] = 8'd255;
			else
				chan_out[ch] = rnd[7:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= s3_v;
	end

	always_ff @(posedge clk) begin
		if (adv && s3_v) begin
			res_q.out_ch0      <= chan_out[0];
			res_q.out_ch1      <= chan_out[1];
			res_q.out_ch2      <= chan_out[2];
			res_q.end_of_frame <= eof_s3;
		end
	end

	// Checks
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_v)
		else $error("bypass flagged with empty stage 1");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s3_v && !adv |=> s3_v)
		else $error("stage 3 item lost during stall");

	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !res_valid_q || res_ready)
		else $error("item taken while pipeline stalled");

endmodule

`default_nettype wire

[tb/sv/tb_conv3x3_rgb_const_border.sv]
// Self-checking testbench for the streaming 3x3 RGB convolution with constant border.
// Holds its own pixel-window predictor, directed and random frame tests.
// Depends on conv3_pkg and conv3x3_rgb_const_border.
`timescale 1ns / 1ps

module tb_conv3x3_rgb_const_border;
	import conv3_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_ready;
	pix_t                  pix;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	conv3x3_rgb_const_border u_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Predictor state: shadow config, line stores, window, positions
	logic [47:0] coef_row [3];
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	logic [7:0]  border_reg;
	logic [23:0] line_prev [MAX_WIDTH_DEF];
	logic [23:0] line_cur  [MAX_WIDTH_DEF];
	logic [23:0] window [9];
	int unsigned in_col, in_row, out_pos;
	bit          frame_done;

	res_t        filtered_q [$];
	int          errors;
	int          items_sent;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("[conv3x3_rgb_const_border] ERROR");
		$finish;
	end

	// Receiver stall
	always @(negedge clk) begin
		res_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
	end

	// Result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res);
				errors++;
			end else begin
				want = filtered_q.pop_front();
				if (res.out_ch0 !== want.out_ch0)
					$display("%0t: out_ch0 exp %h got %h", $time, want.out_ch0, res.out_ch0);
				if (res.out_ch1 !== want.out_ch1)
					$display("%0t: out_ch1 exp %h got %h", $time, want.out_ch1, res.out_ch1);
				if (res.out_ch2 !== want.out_ch2)
					$display("%0t: out_ch2 exp %h got %h", $time, want.out_ch2, res.out_ch2);
				if (res.end_of_frame !== want.end_of_frame)
					$display("%0t: end_of_frame exp %b got %b", $time,
						want.end_of_frame, res.end_of_frame);
				if (res !== want)
					errors++;
			end
		end
	end

	function automatic int unsigned eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic longint coef_of(logic [47:0] rowreg, int m);
		logic signed [15:0] c;
		c = rowreg[m*16 +: 16];
		return longint'(c);
	endfunction

	// Advance the window by one transfer and queue the filtered pixel it yields
	task automatic filter_step(pix_t it);
		int unsigned w, h, x, r, c;
		logic [23:0] bpix, top, mid, bot, tap;
		longint sum [3];
		longint v;
		longint unsigned p;
		bit rout, cout;
		res_t o;
		w = eff_w();
		h = eff_h();
		bpix = {3{border_reg}};
		x = in_col;
		// drain before the image is complete is ignored
		if (in_row < h && it.opcode == OP_DRAIN) return;
		bot = (in_row < h) ? {it.pixel_ch2, it.pixel_ch1, it.pixel_ch0} : bpix;
		top = 0;
		mid = 0;
		if (x < MAX_WIDTH_DEF) begin
			top = line_prev[x];
			mid = line_cur[x];
			line_prev[x] = mid;
			line_cur[x] = bot;
		end
		for (int k = 0; k < 6; k++) window[k] = window[k+3];
		window[6] = top;
		window[7] = mid;
		window[8] = bot;
		p = longint'(in_row) * w + x;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row = (in_row + 1) & 13'h1FFF;
		end
		if (p < w + 1) return;
		r = out_pos / w;
		c = out_pos % w;
		sum = '{0, 0, 0};
		for (int n = 0; n < 3; n++) begin
			rout = (n == 0 && r == 0) || (n == 2 && r + 1 >= h);
			for (int m = 0; m < 3; m++) begin
				cout = (m == 0 && c == 0) || (m == 2 && c + 1 >= w);
				tap = (rout || cout) ? bpix : window[m*3 + n];
				for (int ch = 0; ch < 3; ch++)
					sum[ch] += coef_of(coef_row[n], m) * longint'(tap[ch*8 +: 8]);
			end
		end
		// round half up, saturate once
		for (int ch = 0; ch < 3; ch++) begin
			v = 0;
			if (sum[ch] > 0) begin
				v = (sum[ch] + 2048) >>> 12;
				if (v > 255) v = 255;
			end
			case (ch)
				0: o.out_ch0 = v[7:0];
				1: o.out_ch1 = v[7:0];
				default: o.out_ch2 = v[7:0];
			endcase
		end
		if (longint'(out_pos) >= longint'(w) * h - 1) begin
			o.end_of_frame = 1'b1;
			out_pos = 0;
			in_col = 0;
			in_row = 0;
			frame_done = 1'b1;
		end else begin
			o.end_of_frame = 1'b0;
			out_pos = (out_pos + 1) & 22'h3FFFFF;
		end
		filtered_q.push_back(o);
	endtask

	// One pixel transfer with random gaps ahead of it
	task automatic send_pixel(pix_t it);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 36) begin
			pix_valid = 1'b0;
			@(negedge clk);
		end
		pix_valid = 1'b1;
		pix = it;
		// ready as seen at the edge itself
		@(posedge clk iff pix_ready);
		filter_step(it);
		items_sent++;
	endtask

	// Wait until every queued result has come, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		pix_valid = 1'b0;
		while (filtered_q.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [47:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_COEF_TOP: coef_row[0] = data;
			CFG_COEF_MID: coef_row[1] = data;
			CFG_COEF_BOT: coef_row[2] = data;
			CFG_WIDTH:    width_reg = data[10:0];
			CFG_HEIGHT:   height_reg = data[12:0];
			default:      border_reg = data[7:0];
		endcase
	endtask

	task automatic set_size(int w, int h);
		cfg_write(CFG_WIDTH, 48'(w));
		cfg_write(CFG_HEIGHT, 48'(h));
	endtask

	task automatic set_kernel(logic [47:0] t, logic [47:0] m, logic [47:0] b);
		cfg_write(CFG_COEF_TOP, t);
		cfg_write(CFG_COEF_MID, m);
		cfg_write(CFG_COEF_BOT, b);
	endtask

	function automatic pix_t rand_pixel();
		pix_t it;
		it.opcode = OP_PIXEL;
		it.pixel_ch0 = $urandom;
		it.pixel_ch1 = $urandom;
		it.pixel_ch2 = $urandom;
		return it;
	endfunction

	// Push one frame through; noise adds stray drains and pixels past the end
	task automatic run_frame(int noise_pct, int fixed_val);
		pix_t it;
		frame_done = 1'b0;
		while (!frame_done) begin
			it = rand_pixel();
			if (fixed_val >= 0)
				{it.pixel_ch0, it.pixel_ch1, it.pixel_ch2} = {3{8'(fixed_val)}};
			if (in_row >= eff_h())
				it.opcode = ($urandom_range(99) < noise_pct + 50) ? OP_PIXEL : OP_DRAIN;
			else if ($urandom_range(99) < noise_pct)
				it.opcode = OP_DRAIN;
			send_pixel(it);
		end
		wait_idle();
	endtask

	function automatic logic [47:0] rand_kernel_row();
		logic [15:0] c [3];
		for (int i = 0; i < 3; i++)
			c[i] = ($urandom_range(3) == 0) ? 16'($urandom)
				: 16'($urandom_range(4096) - 2048);
		return {c[2], c[1], c[0]};
	endfunction

	// Default averaging kernel and border on a small frame
	task automatic test_reset_defaults();
		set_size(4, 3);
		run_frame(10, -1);
	endtask

	// Extremes of coefficients, pixels, border and size handling
	task automatic test_directed();
		set_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
		cfg_write(CFG_BORDER, 48'd0);
		set_size(3, 3);
		run_frame(0, 255);
		set_kernel(48'h8000_8000_8000, 48'h8000_1000_8000, 48'h8000_8000_8000);
		cfg_write(CFG_BORDER, 48'd255);
		set_size(0, 0);
		run_frame(0, 0);
		set_kernel(48'h0000_0000_0000, 48'h0000_1000_0000, 48'h0000_0000_0000);
		set_size(1, 2);
		run_frame(30, -1);
		// half rounding: 0x0800 * 1 => exactly one half
		set_kernel(48'h0, 48'h0000_0800_0000, 48'h0);
		set_size(2, 1);
		run_frame(0, 1);
	endtask

	// A wide frame streamed with no idling, then a tall narrow one
	task automatic test_large_frames();
		set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
		cfg_write(CFG_BORDER, 48'($urandom_range(255)));
		set_size(200, 2);
		no_idle = 1'b1;
		run_frame(0, -1);
		no_idle = 1'b0;
		set_size(1, 160);
		run_frame(2, -1);
	endtask

	// Random small frames with random kernels and borders
	task automatic test_random_frames();
		while (items_sent < 1550) begin
			set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
			cfg_write(CFG_BORDER, 48'($urandom_range(255)));
			set_size($urandom_range(8, 1), $urandom_range(6, 1));
			no_idle = ($urandom_range(9) == 0);
			run_frame(($urandom_range(3) == 0) ? 15 : 0, -1);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		res_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		items_sent = 0;
		no_idle = 1'b0;
		coef_row = '{COEF_RESET, COEF_RESET, COEF_RESET};
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		border_reg = BORDER_RESET;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			line_prev[i] = '0;
			line_cur[i] = '0;
		end
		for (int i = 0; i < 9; i++) window[i] = '0;
		in_col = 0;
		in_row = 0;
		out_pos = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		test_reset_defaults();
		test_directed();
		test_large_frames();
		test_random_frames();

		wait_idle();
		repeat (20) @(negedge clk);
		if (filtered_q.size() != 0) begin
			$display("%0t: %0d results never came", $time, filtered_q.size());
			errors++;
		end
		if (errors == 0)
			$display("[conv3x3_rgb_const_border] OK");
		else
			$display("[conv3x3_rgb_const_border] ERROR");
		$finish;
	end

endmodule
